[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by blr_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/blr_pkg.sv]
// ----------------------------------------------------------------------------
// blr_pkg
// shared types and codes of the brightness ramp unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blr_pkg;

    localparam int DIV_W  = 17;
    localparam int DIV_CW = $clog2(DIV_W + 1);

    localparam logic [9:0] PERIOD_RST     = 10'd30;
    localparam logic [7:0] MIN_STRIDE_RST = 8'd1;

    localparam int CFG_AW = 3;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        EV_STARTED = 2'd0,
        EV_CHANGED = 2'd1,
        EV_ENDED   = 2'd2
    } t_event;

    typedef enum logic [0:0] {
        REG_UPDATE_PERIOD = 1'b0,
        REG_MIN_STRIDE    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [9:0] update_period;
        logic [7:0] min_stride;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

[design/brightness_linear_ramp_unit.sv]
// ----------------------------------------------------------------------------
// brightness_linear_ramp_unit
// linear brightness ramp generator with a shared iterative divider
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) carries commands: start, stop and
//   timer tick. output channel (o_out_valid / i_out_stall) carries events:
//   started, changed with a level, ended; o_last marks the final event of one
//   command. config (update period, minimum stride) is written over the apb
//   port while the unit is idle.
// timing:
//   a start that changes the level of an idle ramp runs two or three divisions
//   on one 17-bit restoring divider, one quotient bit per cycle, and keeps
//   the input stalled until the last division is done. a tick or stop
//   emits its events (up to three) one after another through the output
//   register; the unit takes the next command as soon as its last
//   event sits in the output register.
// reset:
//   synchronous, active low. the ramp is idle, the current and target levels,
//   stride and step counters are zero, update period is 30 and minimum stride is 1.
// stall:
//   while the receiver stalls, the output register holds its transfer and
//   pending events wait; the input side stays stalled until they are gone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brightness_linear_ramp_unit import blr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [15:0]       i_from_level,
    input  logic [15:0]       i_to_level,
    input  logic [15:0]       i_duration_ms,
    // event channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_event_res,
    output logic [15:0]       o_level,
    output logic              o_last,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_DIV_STEPS  = 5'b00010,
        S_DIV_STRIDE = 5'b00100,
        S_DIV_LIMIT  = 5'b01000,
        S_EMIT       = 5'b10000
    } t_state;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // sequencer
    t_state r_state, n_state;

    // ramp state
    logic        r_active, n_active;
    logic [15:0] r_cur, n_cur;
    logic [15:0] r_tgt, n_tgt;
    logic [16:0] r_stride, n_stride;
    logic [16:0] r_step_limit, n_step_limit;
    logic [16:0] r_step_count, n_step_count;

    // start setup scratch
    logic        r_neg, n_neg;
    logic [16:0] r_cmag, n_cmag;
    logic [16:0] r_steps, n_steps;
    logic [16:0] r_mag, n_mag;

    // pending events of the current command
    logic        r_p_started, n_p_started;
    logic        r_p_changed, n_p_changed;
    logic        r_p_ended, n_p_ended;
    logic [15:0] r_p_level, n_p_level;

    // output register
    logic        r_out_valid, n_out_valid;
    t_event      r_out_ev, n_out_ev;
    logic [15:0] r_out_level, n_out_level;
    logic        r_out_last, n_out_last;

    logic        in_acc;
    logic        slot_free;
    t_cmd        cmd;

    // start arithmetic
    logic        up;
    logic [16:0] chg_mag;
    logic [16:0] period_eff;
    logic [16:0] steps_eff;
    logic [16:0] min_ext;
    logic [16:0] mag_adj;

    // tick arithmetic
    logic [16:0]        cnt_inc;
    logic               in_limit;
    logic signed [17:0] nxt;
    logic signed [17:0] tgt_s;
    logic               stride_pos;
    logic               out_of_range;

    blr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    blr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign cmd        = t_cmd'(i_cmd);
    assign slot_free  = !r_out_valid || !i_out_stall;

    // change magnitude and sign of a start
    assign up         = (i_to_level >= i_from_level);
    assign chg_mag    = up ? ({1'b0, i_to_level} - {1'b0, i_from_level})
                           : ({1'b0, i_from_level} - {1'b0, i_to_level});
    // a zero period counts as one
    assign period_eff = (cfg.update_period == 10'd0) ? 17'd1
                                                     : {7'd0, cfg.update_period};
    assign steps_eff  = (div_rsp.quotient == 17'd0) ? 17'd1 : div_rsp.quotient;
    assign min_ext    = {9'd0, cfg.min_stride};
    assign mag_adj    = (div_rsp.quotient < min_ext) ? min_ext : div_rsp.quotient;

    // one tick: advance, then check against target with signed compare
    assign cnt_inc      = r_step_count + 17'd1;
    assign in_limit     = (cnt_inc <= r_step_limit);
    assign nxt          = $signed({2'b00, r_cur}) + $signed({r_stride[16], r_stride});
    assign tgt_s        = $signed({2'b00, r_tgt});
    assign stride_pos   = !r_stride[16] && (r_stride != 17'd0);
    assign out_of_range = stride_pos ? (nxt >= tgt_s) : (nxt <= tgt_s);

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_cur        = r_cur;
        n_tgt        = r_tgt;
        n_stride     = r_stride;
        n_step_limit = r_step_limit;
        n_step_count = r_step_count;
        n_neg        = r_neg;
        n_cmag       = r_cmag;
        n_steps      = r_steps;
        n_mag        = r_mag;
        n_p_started  = r_p_started;
        n_p_changed  = r_p_changed;
        n_p_ended    = r_p_ended;
        n_p_level    = r_p_level;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_ev     = r_out_ev;
        n_out_level  = r_out_level;
        n_out_last   = r_out_last;

        div_req.start    = 1'b0;
        div_req.dividend = r_cmag;
        div_req.divisor  = steps_eff;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (cmd)
                        CMD_START: begin
                            if (!r_active) begin
                                n_cur  = i_from_level;
                                n_tgt  = i_to_level;
                                n_neg  = !up;
                                n_cmag = chg_mag;
                                // zero change loads the levels and stays idle
                                if (chg_mag != 17'd0) begin
                                    div_req.start    = 1'b1;
                                    div_req.dividend = {1'b0, i_duration_ms};
                                    div_req.divisor  = period_eff;
                                    n_state          = S_DIV_STEPS;
                                end
                            end
                        end
                        CMD_STOP: begin
                            n_active    = 1'b0;
                            n_p_started = 1'b0;
                            n_p_changed = 1'b0;
                            n_p_ended   = 1'b1;
                            n_state     = S_EMIT;
                        end
                        CMD_TICK: begin
                            if (r_active) begin
                                n_step_count = cnt_inc;
                                n_p_started  = (cnt_inc == 17'd1);
                                n_p_changed  = 1'b1;
                                if (in_limit && !out_of_range) begin
                                    n_cur     = nxt[15:0];
                                    n_p_level = nxt[15:0];
                                    n_p_ended = 1'b0;
                                end else begin
                                    // target reached or step budget spent
                                    n_cur     = r_tgt;
                                    n_p_level = r_tgt;
                                    n_p_ended = 1'b1;
                                    n_active  = 1'b0;
                                end
                                n_state = S_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV_STEPS: begin
                if (div_rsp.done) begin
                    n_steps          = steps_eff;
                    div_req.start    = 1'b1;
                    div_req.dividend = r_cmag;
                    div_req.divisor  = steps_eff;
                    n_state          = S_DIV_STRIDE;
                end
            end
            S_DIV_STRIDE: begin
                if (div_rsp.done) begin
                    n_mag = mag_adj;
                    if ((r_steps > 17'd1) && (mag_adj != 17'd0)) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = r_cmag;
                        div_req.divisor  = mag_adj;
                        n_state          = S_DIV_LIMIT;
                    end else begin
                        n_stride     = r_neg ? (17'd0 - mag_adj) : mag_adj;
                        n_step_limit = r_steps;
                        n_step_count = '0;
                        n_active     = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_DIV_LIMIT: begin
                if (div_rsp.done) begin
                    n_stride     = r_neg ? (17'd0 - r_mag) : r_mag;
                    n_step_limit = div_rsp.quotient;
                    n_step_count = '0;
                    n_active     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                // move one pending event per cycle into the output register while the slot is free
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_p_started) begin
                        n_out_ev    = EV_STARTED;
                        n_out_level = '0;
                        n_out_last  = !(r_p_changed || r_p_ended);
                        n_p_started = 1'b0;
                    end else if (r_p_changed) begin
                        n_out_ev    = EV_CHANGED;
                        n_out_level = r_p_level;
                        n_out_last  = !r_p_ended;
                        n_p_changed = 1'b0;
                    end else begin
                        n_out_ev    = EV_ENDED;
                        n_out_level = '0;
                        n_out_last  = 1'b1;
                        n_p_ended   = 1'b0;
                    end
                    if (n_out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= 1'b0;
            r_cur        <= '0;
            r_tgt        <= '0;
            r_stride     <= '0;
            r_step_limit <= '0;
            r_step_count <= '0;
            r_p_started  <= 1'b0;
            r_p_changed  <= 1'b0;
            r_p_ended    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_cur        <= n_cur;
            r_tgt        <= n_tgt;
            r_stride     <= n_stride;
            r_step_limit <= n_step_limit;
            r_step_count <= n_step_count;
            r_p_started  <= n_p_started;
            r_p_changed  <= n_p_changed;
            r_p_ended    <= n_p_ended;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_neg       <= n_neg;
        r_cmag      <= n_cmag;
        r_steps     <= n_steps;
        r_mag       <= n_mag;
        r_p_level   <= n_p_level;
        r_out_ev    <= n_out_ev;
        r_out_level <= n_out_level;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_out_ev;
    assign o_level     = r_out_level;
    assign o_last      = r_out_last;

endmodule

[design/blr_div.sv]
// ----------------------------------------------------------------------------
// blr_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blr_div import blr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_den;

    logic [DIV_W:0]    rem_sh;
    logic [DIV_W:0]    diff;

    // shift in next dividend bit, trial subtract
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= diff[DIV_W] ? rem_sh[DIV_W-1:0] : diff[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ~diff[DIV_W]};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[design/blr_cfg.sv]
// ----------------------------------------------------------------------------
// blr_cfg
// register file behind the apb-style configuration port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blr_cfg import blr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [9:0] r_update_period;
    logic [7:0] r_min_stride;
    logic       wr_en;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_period <= PERIOD_RST;
            r_min_stride    <= MIN_STRIDE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_UPDATE_PERIOD: r_update_period <= pwdata[9:0];
                REG_MIN_STRIDE:    r_min_stride    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_UPDATE_PERIOD: prdata = {22'd0, r_update_period};
            REG_MIN_STRIDE:    prdata = {24'd0, r_min_stride};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.update_period = r_update_period;
    assign o_cfg.min_stride    = r_min_stride;

endmodule

[design/blr_checker.sv]
// ----------------------------------------------------------------------------
// blr_checker
// port-level checks of the brightness ramp unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blr_checker import blr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [1:0]        i_cmd,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_event_res,
    input logic [15:0]       o_level,
    input logic              o_last
);

    // stalled transfer stays offered
    `BLR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "output transfer dropped while stalled")

    // stalled transfer keeps its payload
    `BLR_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_event_res) && $stable(o_level) && $stable(o_last), "output payload changed while stalled")

    // started and ended events carry no level
    `BLR_ASSERT_IMP(a_lvl_zero, i_clk, i_rst_n, o_out_valid && (o_event_res == EV_STARTED || o_event_res == EV_ENDED), o_level == 16'd0, "level not zero on started or ended")

    // ended closes the command, started never does
    `BLR_ASSERT_IMP(a_last_flag, i_clk, i_rst_n, o_out_valid, (o_event_res != EV_ENDED || o_last) && (o_event_res != EV_STARTED || !o_last), "last flag wrong for event")

    // a stop always leaves an event to deliver, so input stalls next
    `BLR_ASSERT_NXT(a_stop_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_cmd == CMD_STOP, o_in_stall, "stop transfer did not occupy the unit")

endmodule

bind brightness_linear_ramp_unit blr_checker u_blr_checker (.*);
